[hw/rtl/rqop_pkg.sv]
package rqop_pkg;

    // Storage geometry of the slot memory.
    localparam int DEPTH       = 64;
    localparam int ENTRY_WIDTH = 64;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Port and register widths fixed by the interface.
    localparam int WORD_W     = 64;
    localparam int CAP_W      = 7;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int STAT_W     = 32;
    localparam int SEL_W      = 3;
    localparam int NUM_CNT    = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW = 1'b1;

    // Full-queue rules; any other code acts as block.
    localparam logic [MODE_W-1:0] MODE_DROP_NEWEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DROP_OLDEST = 2'd1;

    // Event counter slots.
    localparam logic [SEL_W-1:0] CNT_ENQUEUED  = 3'd0;
    localparam logic [SEL_W-1:0] CNT_DEQUEUED  = 3'd1;
    localparam logic [SEL_W-1:0] CNT_DROP_NEW  = 3'd2;
    localparam logic [SEL_W-1:0] CNT_DROP_OLD  = 3'd3;
    localparam logic [SEL_W-1:0] CNT_TIMEOUT   = 3'd4;
    localparam logic [SEL_W-1:0] SEL_SIZE      = 3'd5;
    localparam logic [SEL_W-1:0] SEL_MAX_SIZE  = 3'd6;

    typedef enum logic [2:0] {
        OP_ENQUEUE     = 3'd0,
        OP_DEQUEUE     = 3'd1,
        OP_PEEK        = 3'd2,
        OP_DRAIN       = 3'd3,
        OP_CLOSE_DRAIN = 3'd4,
        OP_CLOSE       = 3'd5,
        OP_READ_STAT   = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        STS_ACCEPTED      = 3'd0,
        STS_CLOSED        = 3'd1,
        STS_DROPPED_NEWEST = 3'd2,
        STS_TIMED_OUT     = 3'd3,
        STS_NOTIFY_FAILED = 3'd4,
        STS_EMPTY         = 3'd5,
        STS_DONE          = 3'd6
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } fsm_t;

endpackage

[hw/rtl/ring_queue_with_overflow_policy_core.sv]
// Channel   | Handshake                 | Word
// ----------+---------------------------+------------------------------------------
// command   | start, busy (out)         | operation, entry_in, notify_wanted,
//           |                           | notify_succeeded, stat_select
// config    | cfg_write                 | cfg_index, cfg_data
// result    | strobe (out)              | status, entry_out, entry_valid,
//           |                           | evicted_entry, evicted_valid,
//           |                           | notify_sent, stat_value, last_of_run
//
// A command is taken when start is high and busy is low. The head slot is read
// in that cycle and the command executes in the next one, since the slot memory
// read is registered. The result word shows in the cycle after it is computed;
// busy already falls in the cycle of the last word, so the next command may be
// taken then. Drain and close-and-drain give one word per cycle.
// Reset empties the queue, clears the counters and sets capacity to 64 with the
// drop-newest rule; the slot memory is not cleared. The receiver cannot stall.
module ring_queue_with_overflow_policy_core
    import rqop_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            operation,
    input  logic [WORD_W-1:0]     entry_in,
    input  logic                  notify_wanted,
    input  logic                  notify_succeeded,
    input  logic [SEL_W-1:0]      stat_select,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  strobe,
    output logic [2:0]            status,
    output logic [WORD_W-1:0]     entry_out,
    output logic                  entry_valid,
    output logic [WORD_W-1:0]     evicted_entry,
    output logic                  evicted_valid,
    output logic                  notify_sent,
    output logic [STAT_W-1:0]     stat_value,
    output logic                  last_of_run
);

    // Control state.
    fsm_t                   state_reg, state_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       peak_reg, peak_next;
    logic                   closed_reg, closed_next;
    logic [STAT_W-1:0]      cnt_reg [NUM_CNT];
    logic [STAT_W-1:0]      cnt_next [NUM_CNT];
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;

    // Command captured at acceptance.
    logic [2:0]             op_reg;
    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic                   notify_wanted_reg;
    logic                   notify_ok_reg;
    logic [SEL_W-1:0]       sel_reg;

    // Result word.
    logic                   strobe_reg, strobe_next;
    status_t                status_reg, status_next;
    logic [WORD_W-1:0]      entry_out_reg, entry_out_next;
    logic                   entry_valid_reg, entry_valid_next;
    logic [WORD_W-1:0]      evicted_reg, evicted_next;
    logic                   evicted_valid_reg, evicted_valid_next;
    logic                   notified_reg, notified_next;
    logic [STAT_W-1:0]      stat_reg, stat_next;
    logic                   last_reg, last_next;

    // Slot memory port.
    logic                   ram_we;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    logic                   accept;
    logic [CAP_W-1:0]       cap_eff;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Capacity clamped into 1..DEPTH.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (cap_reg > CAP_W'(DEPTH))
        begin
            cap_eff = CAP_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // Ring index step with wrap at the active capacity.
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
        if (CAP_W'(idx) == cap - CAP_W'(1))
        begin
            return '0;
        end
        return idx + IDX_W'(1);
    endfunction

    // The head slot is always being read, so its word is ready in the next cycle.
    rqop_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (entry_reg),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // Next state, queue update and result word.
    always_comb
    begin
        logic full;
        logic [CNT_W-1:0] fill_inc;

        full     = CAP_W'(fill_reg) >= cap_eff;
        fill_inc = fill_reg + CNT_W'(1);

        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        peak_next   = peak_reg;
        closed_next = closed_reg;
        cap_next    = cap_reg;
        mode_next   = mode_reg;
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        ram_we = 1'b0;

        strobe_next        = 1'b0;
        status_next        = STS_ACCEPTED;
        entry_out_next     = '0;
        entry_valid_next   = 1'b0;
        evicted_next       = '0;
        evicted_valid_next = 1'b0;
        notified_next      = 1'b0;
        stat_next          = '0;
        last_next          = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
                case (op_reg)
                    OP_ENQUEUE:
                    begin
                        if (closed_reg)
                        begin
                            status_next = STS_CLOSED;
                        end
                        else if (full && mode_reg == MODE_DROP_NEWEST)
                        begin
                            cnt_next[CNT_DROP_NEW] = cnt_reg[CNT_DROP_NEW] + STAT_W'(1);
                            status_next = STS_DROPPED_NEWEST;
                        end
                        else if (full && mode_reg == MODE_DROP_OLDEST)
                        begin
                            // Evict the head and put the new entry in its place.
                            evicted_next           = WORD_W'(ram_rdata);
                            evicted_valid_next     = 1'b1;
                            head_next              = advance(head_reg, cap_eff);
                            tail_next              = advance(tail_reg, cap_eff);
                            ram_we                 = 1'b1;
                            cnt_next[CNT_DROP_OLD] = cnt_reg[CNT_DROP_OLD] + STAT_W'(1);
                            cnt_next[CNT_ENQUEUED] = cnt_reg[CNT_ENQUEUED] + STAT_W'(1);
                            if (fill_reg > peak_reg)
                            begin
                                peak_next = fill_reg;
                            end
                        end
                        else if (full)
                        begin
                            cnt_next[CNT_TIMEOUT] = cnt_reg[CNT_TIMEOUT] + STAT_W'(1);
                            status_next = STS_TIMED_OUT;
                        end
                        else
                        begin
                            if (fill_inc > peak_reg)
                            begin
                                peak_next = fill_inc;
                            end
                            // A failed wake-up of an empty queue undoes the enqueue.
                            if (fill_reg == '0 && notify_wanted_reg && !notify_ok_reg)
                            begin
                                status_next = STS_NOTIFY_FAILED;
                            end
                            else
                            begin
                                ram_we                 = 1'b1;
                                tail_next              = advance(tail_reg, cap_eff);
                                fill_next              = fill_inc;
                                cnt_next[CNT_ENQUEUED] = cnt_reg[CNT_ENQUEUED] + STAT_W'(1);
                                notified_next          = (fill_reg == '0) && notify_wanted_reg;
                            end
                        end
                    end
                    OP_DEQUEUE, OP_PEEK:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else
                        begin
                            entry_out_next   = WORD_W'(ram_rdata);
                            entry_valid_next = 1'b1;
                            if (op_reg == OP_DEQUEUE)
                            begin
                                head_next = advance(head_reg, cap_eff);
                                fill_next = fill_reg - CNT_W'(1);
                                cnt_next[CNT_DEQUEUED] = cnt_reg[CNT_DEQUEUED] + STAT_W'(1);
                            end
                        end
                    end
                    OP_DRAIN, OP_CLOSE_DRAIN:
                    begin
                        status_next = STS_DONE;
                        if (op_reg == OP_CLOSE_DRAIN)
                        begin
                            closed_next = 1'b1;
                        end
                        if (fill_reg != '0)
                        begin
                            // One entry a cycle; the next head is read meanwhile.
                            entry_out_next   = WORD_W'(ram_rdata);
                            entry_valid_next = 1'b1;
                            head_next        = advance(head_reg, cap_eff);
                            fill_next        = fill_reg - CNT_W'(1);
                            if (fill_reg != CNT_W'(1))
                            begin
                                last_next  = 1'b0;
                                state_next = ST_EXEC;
                            end
                            else
                            begin
                                tail_next = advance(head_reg, cap_eff);
                            end
                        end
                    end
                    OP_CLOSE:
                    begin
                        closed_next = 1'b1;
                        status_next = STS_DONE;
                    end
                    OP_READ_STAT:
                    begin
                        if (sel_reg < SEL_W'(NUM_CNT))
                        begin
                            stat_next = cnt_reg[sel_reg];
                        end
                        else if (sel_reg == SEL_SIZE)
                        begin
                            stat_next = STAT_W'(fill_reg);
                        end
                        else if (sel_reg == SEL_MAX_SIZE)
                        begin
                            stat_next = STAT_W'(peak_reg);
                        end
                    end
                    default:
                    begin
                        status_next = STS_DONE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes must arrive only while idle; the block itself does not enforce this.
        if (cfg_write)
        begin
            case (cfg_index)
                REG_CAPACITY:
                begin
                    cap_next  = cfg_data;
                    head_next = '0;
                    tail_next = '0;
                    fill_next = '0;
                end
                REG_OVERFLOW:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            peak_reg   <= '0;
            closed_reg <= 1'b0;
            cap_reg    <= CAP_W'(DEPTH);
            mode_reg   <= MODE_DROP_NEWEST;
            strobe_reg <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            peak_reg   <= peak_next;
            closed_reg <= closed_next;
            cap_reg    <= cap_next;
            mode_reg   <= mode_next;
            strobe_reg <= strobe_next;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Command capture and result word; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg            <= operation;
            entry_reg         <= entry_in[ENTRY_WIDTH-1:0];
            notify_wanted_reg <= notify_wanted;
            notify_ok_reg     <= notify_succeeded;
            sel_reg           <= stat_select;
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg        <= status_next;
            entry_out_reg     <= entry_out_next;
            entry_valid_reg   <= entry_valid_next;
            evicted_reg       <= evicted_next;
            evicted_valid_reg <= evicted_valid_next;
            notified_reg      <= notified_next;
            stat_reg          <= stat_next;
            last_reg          <= last_next;
        end
    end

    assign strobe            = strobe_reg;
    assign status            = status_reg;
    assign entry_out         = entry_out_reg;
    assign entry_valid       = entry_valid_reg;
    assign evicted_entry     = evicted_reg;
    assign evicted_valid     = evicted_valid_reg;
    assign notify_sent       = notified_reg;
    assign stat_value        = stat_reg;
    assign last_of_run       = last_reg;

    // Head and tail stay inside the active ring.
    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        CAP_W'(head_reg) < cap_eff && CAP_W'(tail_reg) < cap_eff)
        else $error("ring index outside active capacity");

    // An empty queue has its head and tail together.
    a_empty_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with head and tail apart");

    // A word that is not the last of its run means the block is still busy.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |-> busy)
        else $error("run continues while block is idle");

    // Every accepted command produces a result word once it has executed.
    a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 strobe_reg)
        else $error("accepted command gave no result");

    // Fill never exceeds the active capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CAP_W'(fill_reg) <= cap_eff)
        else $error("fill count above capacity");

endmodule

[hw/rtl/rqop_ram.sv]
module rqop_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; a read of the entry being
    // written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[dv/ring_queue_with_overflow_policy_core_test.sv]
module ring_queue_with_overflow_policy_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rqop_pkg::*;

    // Codes that the package leaves without a name.
    localparam logic [2:0]       OP_UNUSED   = 3'd7;
    localparam logic [SEL_W-1:0] SEL_NONE    = 3'd7;
    localparam logic [MODE_W-1:0] MODE_BLOCK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 40;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 23;

    typedef struct packed {
        logic [2:0]        operation;
        logic [WORD_W-1:0] entry;
        logic              notify_wanted;
        logic              notify_succeeded;
        logic [SEL_W-1:0]  stat_select;
    } command_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [WORD_W-1:0] entry_out;
        logic              entry_valid;
        logic [WORD_W-1:0] evicted_entry;
        logic              evicted_valid;
        logic              notify_sent;
        logic [STAT_W-1:0] stat_value;
        logic              last_of_run;
    } result_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [2:0]            operation = '0;
    logic [WORD_W-1:0]     entry_in = '0;
    logic                  notify_wanted = 1'b0;
    logic                  notify_succeeded = 1'b0;
    logic [SEL_W-1:0]      stat_select = '0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  strobe;
    logic [2:0]            status;
    logic [WORD_W-1:0]     entry_out;
    logic                  entry_valid;
    logic [WORD_W-1:0]     evicted_entry;
    logic                  evicted_valid;
    logic                  notify_sent;
    logic [STAT_W-1:0]     stat_value;
    logic                  last_of_run;

    ring_queue_with_overflow_policy_core u_top (.*);

    // Mirror of the queue state.
    logic [ENTRY_WIDTH-1:0] slot_copy [DEPTH];
    int unsigned            head_pos;
    int unsigned            tail_pos;
    int unsigned            fill_level;
    int unsigned            peak_level;
    logic                   closed_now;
    logic [STAT_W-1:0]      event_count [NUM_CNT];
    logic [CAP_W-1:0]       capacity_reg;
    logic [MODE_W-1:0]      overflow_reg;

    command_t     command_backlog [$];
    result_word_t awaited_words [$];
    command_t     cmd_now;
    result_word_t seen_word;
    result_word_t due_word;
    logic         drive_on = 1'b0;
    int unsigned  gap_left = 0;
    int           idle_style = 1;
    int           mismatch_count = 0;
    int           quiet_cycles = 0;

    logic [CFG_DATA_W-1:0] phase_capacity [NUM_PHASES] =
        '{7'd64, 7'd64, 7'd3, 7'd1, 7'd8, 7'd127, 7'd5, 7'd16, 7'd0};
    logic [MODE_W-1:0] phase_rule [NUM_PHASES] =
        '{MODE_DROP_NEWEST, MODE_DROP_OLDEST, MODE_DROP_OLDEST, MODE_BLOCK,
          MODE_DROP_NEWEST, MODE_BLOCK, MODE_SPARE, MODE_DROP_OLDEST, MODE_DROP_OLDEST};

    initial begin
        forever #5 clk = ~clk;
    end

    // Capacity below one acts as one, above the depth as the depth.
    function automatic int unsigned slots_in_use();
        if (capacity_reg == '0) return 1;
        if (int'(capacity_reg) > DEPTH) return DEPTH;
        return int'(capacity_reg);
    endfunction

    function automatic int unsigned next_slot(int unsigned i);
        return (i + 1) % slots_in_use();
    endfunction

    // Work out every word that one accepted command produces and queue them.
    function automatic void predict_command(command_t cmd);
        result_word_t          w;
        result_word_t          run [$];
        int unsigned           lim;
        logic                  notify_needed;
        logic                  evicted;
        logic [ENTRY_WIDTH-1:0] evicted_val;
        lim = slots_in_use();
        w = '0;
        notify_needed = (fill_level == 0);
        evicted = 1'b0;
        evicted_val = '0;
        case (cmd.operation)
            OP_ENQUEUE: begin
                w.status = STS_ACCEPTED;
                if (closed_now) begin
                    w.status = STS_CLOSED;
                end else if (fill_level >= lim && overflow_reg == MODE_DROP_NEWEST) begin
                    event_count[CNT_DROP_NEW]++;
                    w.status = STS_DROPPED_NEWEST;
                end else if (fill_level >= lim && overflow_reg != MODE_DROP_OLDEST) begin
                    event_count[CNT_TIMEOUT]++;
                    w.status = STS_TIMED_OUT;
                end else begin
                    if (fill_level >= lim) begin
                        evicted_val = slot_copy[head_pos];
                        evicted = 1'b1;
                        head_pos = next_slot(head_pos);
                        fill_level--;
                        event_count[CNT_DROP_OLD]++;
                        notify_needed = 1'b0;
                    end
                    slot_copy[tail_pos] = cmd.entry[ENTRY_WIDTH-1:0];
                    tail_pos = next_slot(tail_pos);
                    fill_level++;
                    event_count[CNT_ENQUEUED]++;
                    if (fill_level > peak_level) peak_level = fill_level;
                    // A failed notification undoes the enqueue but not the peak.
                    if (notify_needed && cmd.notify_wanted) begin
                        if (!cmd.notify_succeeded) begin
                            tail_pos = (tail_pos == 0) ? lim - 1 : tail_pos - 1;
                            fill_level--;
                            event_count[CNT_ENQUEUED]--;
                            w.status = STS_NOTIFY_FAILED;
                        end else begin
                            w.notify_sent = 1'b1;
                        end
                    end
                    if (evicted) begin
                        w.evicted_entry = WORD_W'(evicted_val);
                        w.evicted_valid = 1'b1;
                    end
                end
                run.insert(run.size(), w);
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (fill_level == 0) begin
                    w.status = STS_EMPTY;
                end else begin
                    w.status = STS_ACCEPTED;
                    w.entry_out = WORD_W'(slot_copy[head_pos]);
                    w.entry_valid = 1'b1;
                    if (cmd.operation == OP_DEQUEUE) begin
                        head_pos = next_slot(head_pos);
                        fill_level--;
                        event_count[CNT_DEQUEUED]++;
                    end
                end
                run.insert(run.size(), w);
            end
            OP_DRAIN, OP_CLOSE_DRAIN: begin
                if (cmd.operation == OP_CLOSE_DRAIN) closed_now = 1'b1;
                while (fill_level != 0) begin
                    w = '0;
                    w.status = STS_DONE;
                    w.entry_out = WORD_W'(slot_copy[head_pos]);
                    w.entry_valid = 1'b1;
                    run.insert(run.size(), w);
                    head_pos = next_slot(head_pos);
                    fill_level--;
                end
                tail_pos = head_pos;
                if (run.size() == 0) begin
                    w = '0;
                    w.status = STS_DONE;
                    run.insert(run.size(), w);
                end
            end
            OP_CLOSE: begin
                closed_now = 1'b1;
                w.status = STS_DONE;
                run.insert(run.size(), w);
            end
            OP_READ_STAT: begin
                w.status = STS_ACCEPTED;
                if (cmd.stat_select <= CNT_TIMEOUT) w.stat_value = event_count[cmd.stat_select];
                else if (cmd.stat_select == SEL_SIZE) w.stat_value = STAT_W'(fill_level);
                else if (cmd.stat_select == SEL_MAX_SIZE) w.stat_value = STAT_W'(peak_level);
                run.insert(run.size(), w);
            end
            default: begin
                w.status = STS_DONE;
                run.insert(run.size(), w);
            end
        endcase
        foreach (run[i]) begin
            w = run[i];
            w.last_of_run = (i == run.size() - 1);
            awaited_words.insert(awaited_words.size(), w);
        end
    endfunction

    function automatic void queue_command(logic [2:0] op, logic [WORD_W-1:0] ent,
                                          logic nw, logic ns, logic [SEL_W-1:0] sel);
        command_t c;
        c.operation = op;
        c.entry = ent;
        c.notify_wanted = nw;
        c.notify_succeeded = ns;
        c.stat_select = sel;
        command_backlog.insert(command_backlog.size(), c);
    endfunction

    // Enqueue-heavy mix; close commands only once the queue may stay closed.
    function automatic command_t random_command(bit may_close);
        command_t    c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 48) c.operation = OP_ENQUEUE;
        else if (pick < 63) c.operation = OP_DEQUEUE;
        else if (pick < 71) c.operation = OP_PEEK;
        else if (pick < 77) c.operation = OP_DRAIN;
        else if (pick < 91) c.operation = OP_READ_STAT;
        else if (pick < 94) c.operation = OP_UNUSED;
        else if (!may_close) c.operation = OP_ENQUEUE;
        else if (pick < 97) c.operation = OP_CLOSE;
        else c.operation = OP_CLOSE_DRAIN;
        pick = $urandom_range(0, 19);
        if (pick == 0) c.entry = '1;
        else if (pick == 1) c.entry = '0;
        else c.entry = {$urandom(), $urandom()};
        c.notify_wanted = 1'($urandom_range(0, 1));
        c.notify_succeeded = ($urandom_range(0, 3) != 0);
        c.stat_select = SEL_W'($urandom_range(0, 7));
        return c;
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned r;
        if (idle_style == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
    endtask

    task automatic wait_until_idle();
        do @(posedge clk);
        while (command_backlog.size() != 0 || drive_on || start || busy ||
               awaited_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes only happen with nothing in flight.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_until_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_CAPACITY) begin
            capacity_reg = data;
            head_pos = 0;
            tail_pos = 0;
            fill_level = 0;
        end else begin
            overflow_reg = data[MODE_W-1:0];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Command driver: predicts each word set at the edge that takes the command.
    always @(posedge clk) begin
        if (rst_n) begin
            drive_on = start;
            if (start && !busy) begin
                predict_command(cmd_now);
                drive_on = 1'b0;
                gap_left = sender_gap();
            end
            if (!drive_on) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (command_backlog.size() != 0) begin
                    cmd_now = command_backlog.pop_front();
                    operation <= cmd_now.operation;
                    entry_in <= cmd_now.entry;
                    notify_wanted <= cmd_now.notify_wanted;
                    notify_succeeded <= cmd_now.notify_succeeded;
                    stat_select <= cmd_now.stat_select;
                    drive_on = 1'b1;
                end
            end
            start <= drive_on;
        end
    end

    // Result monitor: every strobed word is matched against the oldest one due.
    always @(posedge clk) begin
        if (rst_n && strobe === 1'b1) begin
            seen_word = {status, entry_out, entry_valid, evicted_entry, evicted_valid,
                         notify_sent, stat_value, last_of_run};
            if (awaited_words.size() == 0) begin
                report_mismatch("unexpected word, status", WORD_W'(status), '0);
            end else begin
                due_word = awaited_words.pop_front();
                if (seen_word.status !== due_word.status)
                    report_mismatch("status", WORD_W'(seen_word.status),
                                    WORD_W'(due_word.status));
                if (seen_word.entry_out !== due_word.entry_out)
                    report_mismatch("entry_out", seen_word.entry_out, due_word.entry_out);
                if (seen_word.entry_valid !== due_word.entry_valid)
                    report_mismatch("entry_valid", WORD_W'(seen_word.entry_valid),
                                    WORD_W'(due_word.entry_valid));
                if (seen_word.evicted_entry !== due_word.evicted_entry)
                    report_mismatch("evicted_entry", seen_word.evicted_entry,
                                    due_word.evicted_entry);
                if (seen_word.evicted_valid !== due_word.evicted_valid)
                    report_mismatch("evicted_valid", WORD_W'(seen_word.evicted_valid),
                                    WORD_W'(due_word.evicted_valid));
                if (seen_word.notify_sent !== due_word.notify_sent)
                    report_mismatch("notify_sent", WORD_W'(seen_word.notify_sent),
                                    WORD_W'(due_word.notify_sent));
                if (seen_word.stat_value !== due_word.stat_value)
                    report_mismatch("stat_value", WORD_W'(seen_word.stat_value),
                                    WORD_W'(due_word.stat_value));
                if (seen_word.last_of_run !== due_word.last_of_run)
                    report_mismatch("last_of_run", WORD_W'(seen_word.last_of_run),
                                    WORD_W'(due_word.last_of_run));
            end
        end
    end

    // Watchdog: counts cycles in which no command, word or write goes through.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe === 1'b1 || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        head_pos = 0;
        tail_pos = 0;
        fill_level = 0;
        peak_level = 0;
        closed_now = 1'b0;
        foreach (event_count[i]) event_count[i] = '0;
        foreach (slot_copy[i]) slot_copy[i] = '0;
        capacity_reg = CAP_W'(DEPTH);
        overflow_reg = MODE_DROP_NEWEST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty-queue cases, notification outcomes and the odd codes.
        queue_command(OP_PEEK, '0, 1'b0, 1'b0, '0);
        queue_command(OP_DEQUEUE, '0, 1'b0, 1'b0, '0);
        queue_command(OP_DRAIN, '0, 1'b0, 1'b0, '0);
        queue_command(OP_ENQUEUE, '1, 1'b1, 1'b1, '0);
        queue_command(OP_ENQUEUE, '0, 1'b1, 1'b0, '0);
        queue_command(OP_PEEK, '0, 1'b0, 1'b0, '0);
        queue_command(OP_DEQUEUE, '0, 1'b0, 1'b0, '0);
        queue_command(OP_DEQUEUE, '0, 1'b0, 1'b0, '0);
        queue_command(OP_ENQUEUE, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, '0);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, SEL_SIZE);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, CNT_ENQUEUED);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, SEL_MAX_SIZE);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, SEL_NONE);
        queue_command(OP_UNUSED, '1, 1'b1, 1'b1, SEL_NONE);
        queue_command(OP_ENQUEUE, {32{2'b01}}, 1'b0, 1'b0, '0);
        queue_command(OP_ENQUEUE, {32{2'b10}}, 1'b0, 1'b0, '0);
        queue_command(OP_DRAIN, '0, 1'b0, 1'b0, '0);

        // Each full-queue rule on a two-slot queue.
        write_register(REG_CAPACITY, 7'd2);
        repeat (3) queue_command(OP_ENQUEUE, {$urandom(), $urandom()}, 1'b0, 1'b0, '0);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, CNT_DROP_NEW);
        write_register(REG_OVERFLOW, {5'b0, MODE_DROP_OLDEST});
        queue_command(OP_ENQUEUE, {$urandom(), $urandom()}, 1'b0, 1'b0, '0);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, CNT_DROP_OLD);
        write_register(REG_OVERFLOW, {5'b11111, MODE_BLOCK});
        queue_command(OP_ENQUEUE, {$urandom(), $urandom()}, 1'b0, 1'b0, '0);
        write_register(REG_OVERFLOW, {5'b0, MODE_SPARE});
        queue_command(OP_ENQUEUE, {$urandom(), $urandom()}, 1'b0, 1'b0, '0);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, CNT_TIMEOUT);

        // Random phases over a range of capacities and rules.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_register(REG_CAPACITY, phase_capacity[p]);
            write_register(REG_OVERFLOW,
                           {(CFG_DATA_W - MODE_W)'($urandom()), phase_rule[p]});
            idle_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
            // Large queues rarely fill by chance, so fill them past the top first.
            if (phase_capacity[p] >= 7'd32) begin
                repeat (DEPTH + 2) queue_command(OP_ENQUEUE, {$urandom(), $urandom()},
                                                 1'($urandom_range(0, 1)), 1'b1, '0);
                queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, SEL_MAX_SIZE);
                queue_command(OP_DRAIN, '0, 1'b0, 1'b0, '0);
            end
            repeat (PHASE_ITEMS)
                command_backlog.insert(command_backlog.size(), random_command(1'b0));
        end

        // Closing is permanent, so it comes last.
        write_register(REG_CAPACITY, 7'd6);
        idle_style = 1;
        queue_command(OP_ENQUEUE, {$urandom(), $urandom()}, 1'b0, 1'b0, '0);
        queue_command(OP_ENQUEUE, {$urandom(), $urandom()}, 1'b0, 1'b0, '0);
        queue_command(OP_ENQUEUE, {$urandom(), $urandom()}, 1'b0, 1'b0, '0);
        queue_command(OP_CLOSE, '0, 1'b0, 1'b0, '0);
        queue_command(OP_ENQUEUE, '1, 1'b1, 1'b1, '0);
        queue_command(OP_PEEK, '0, 1'b0, 1'b0, '0);
        queue_command(OP_DEQUEUE, '0, 1'b0, 1'b0, '0);
        queue_command(OP_CLOSE_DRAIN, '0, 1'b0, 1'b0, '0);
        queue_command(OP_CLOSE_DRAIN, '0, 1'b0, 1'b0, '0);
        queue_command(OP_READ_STAT, '0, 1'b0, 1'b0, CNT_DEQUEUED);
        repeat (20) command_backlog.insert(command_backlog.size(), random_command(1'b1));

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
